@@ src/cos_squared_half_series_macros.svh @@
// Assertion macros shared by the checker of cos_squared_half_series.
// Self-contained; taken in by `include wherever assertions are written.
`ifndef COS_SQUARED_HALF_SERIES_MACROS_SVH
`define COS_SQUARED_HALF_SERIES_MACROS_SVH

// same-cycle implication, off while reset is held
`define CSH_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define CSH_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/csh_pkg.sv @@
// Constants, widths and the inter-stage word type of the cos^2(x/2) series pipeline.
// No dependencies; imported by csh_term, cos_squared_half_series and csh_checker.
package csh_pkg;

  // number of series term stages built into the pipeline
  localparam int unsigned MAX_TERMS = 32;

  // port field widths
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TC_W    = 6;

  // configuration port
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT = '0;
  localparam logic [TC_W-1:0]      TC_RESET       = TC_W'(32);

  // multiplier limb width
  localparam int unsigned LIMB_W = 32;

  // term magnitude in Q30; the largest term for |x| <= 8 stays below 2^39
  localparam int unsigned MAG_W = 40;
  // x^2 in Q56, at most 2^62
  localparam int unsigned X2_W    = 63;
  localparam int unsigned X2_FRAC = 56;
  localparam int unsigned ACC_W   = MAG_W + X2_W;
  // previous term times x^2 in Q30, below 2^46
  localparam int unsigned Y_W = 46;

  // reciprocal of the divisor scaled by 2^Y_W; divisor >= 4 keeps it in Y_W-1 bits
  localparam int unsigned RECIP_SHIFT = Y_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT - 1;
  localparam int unsigned PROD_W      = Y_W + RECIP_W;
  localparam int unsigned Q0_W        = PROD_W - RECIP_SHIFT;
  localparam int unsigned DIV_W       = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS - 1) + 1);

  // running sum, signed Q30
  localparam int unsigned SUM_W = 48;

  // term index compare width
  localparam int unsigned IDX_W = $clog2(MAX_TERMS + 1);
  localparam int unsigned CMP_W = (IDX_W > TC_W) ? IDX_W : TC_W;

  // seed term 1.0 in Q30
  localparam logic [MAG_W-1:0] SEED = MAG_W'(64'd1073741824);

  // output range
  localparam logic signed [SUM_W-1:0] VALUE_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] VALUE_MIN = ~VALUE_MAX;
  localparam logic [VALUE_W-1:0]      CLIP_HI   = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0]      CLIP_LO   = 32'h8000_0000;

  // word passed from one term stage to the next: the sum so far, x^2, and
  // the newest term still to be added with its sign and inclusion flag
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [X2_W-1:0]         x2;
    logic [MAG_W-1:0]        mag;
    logic                    neg;
    logic                    en;
  } term_word_t;

endpackage

@@ src/csh_term.sv @@
// One series term: adds the pending term to the sum and forms the next term
// as floor(prev * x^2 / (2^56 * d)) over seven register stages. Uses csh_pkg.
module csh_term
  import csh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [DIV_W-1:0]   divisor,
  input  logic [RECIP_W-1:0] recip,
  input  logic               term_en,
  input  logic               in_valid,
  input  term_word_t         in_word,
  output logic               out_valid,
  output term_word_t         out_word
);

  localparam int unsigned MH_W    = MAG_W - LIMB_W;
  localparam int unsigned XH_W    = X2_W - LIMB_W;
  localparam int unsigned YH_W    = Y_W - LIMB_W;
  localparam int unsigned RH_W    = RECIP_W - LIMB_W;
  localparam int unsigned LL_W    = 2 * LIMB_W;
  localparam int unsigned CROSS_W = LIMB_W + ((YH_W > RH_W) ? YH_W : RH_W) + 1;
  localparam int unsigned HH_W    = YH_W + RH_W;
  localparam int unsigned MPROD_W = Q0_W + DIV_W;
  localparam int unsigned NSTAGE  = 7;

  // valid bits of the seven stages
  logic [NSTAGE-1:0] v;

  // stage a: sum update, low limb product
  logic signed [SUM_W-1:0] a_sum;
  logic [X2_W-1:0]         a_x2;
  logic [MAG_W-1:0]        a_mag;
  logic                    a_neg;
  logic [LL_W-1:0]         a_acc;
  logic signed [SUM_W-1:0] pend_ext;
  logic signed [SUM_W-1:0] sum_next;
  logic [LL_W-1:0]         ll;

  // stage b: low term limb by high x^2 limb
  logic signed [SUM_W-1:0]   b_sum;
  logic [X2_W-1:0]           b_x2;
  logic [MH_W-1:0]           b_mh;
  logic                      b_neg;
  logic [ACC_W-1:0]          b_acc;
  logic [LIMB_W+XH_W-1:0]    lh;
  logic [ACC_W-1:0]          b_acc_next;

  // stage c: high term limb by x^2, rescale to Q30
  logic signed [SUM_W-1:0] c_sum;
  logic [X2_W-1:0]         c_x2;
  logic                    c_neg;
  logic [Y_W-1:0]          c_y;
  logic [MH_W+X2_W-1:0]    hx;
  logic [ACC_W-1:0]        c_full;

  // stage d: low limbs of y times reciprocal
  logic signed [SUM_W-1:0] d_sum;
  logic [X2_W-1:0]         d_x2;
  logic                    d_neg;
  logic [Y_W-1:0]          d_y;
  logic [LL_W-1:0]         d_acc;
  logic [LL_W-1:0]         yl_ml;

  // stage e: remaining reciprocal limbs, quotient estimate
  logic signed [SUM_W-1:0] e_sum;
  logic [X2_W-1:0]         e_x2;
  logic                    e_neg;
  logic [Y_W-1:0]          e_y;
  logic [Q0_W-1:0]         e_q0;
  logic [CROSS_W-1:0]      mid_prod;
  logic [HH_W-1:0]         hh;
  logic [PROD_W-1:0]       e_full;

  // stage f: estimate times divisor
  logic signed [SUM_W-1:0] f_sum;
  logic [X2_W-1:0]         f_x2;
  logic                    f_neg;
  logic [Y_W-1:0]          f_y;
  logic [Q0_W-1:0]         f_q0;
  logic [Y_W-1:0]          f_prod;
  logic [MPROD_W-1:0]      mprod;

  // stage g: one-step quotient correction
  logic [Y_W-1:0]  rem;
  logic [Q0_W-1:0] q;

  // pending term folded into the sum, low limb product in parallel
  always_comb begin
    pend_ext = signed'(SUM_W'(in_word.mag));
    if (!in_word.en) begin
      sum_next = in_word.sum;
    end else if (in_word.neg) begin
      sum_next = in_word.sum - pend_ext;
    end else begin
      sum_next = in_word.sum + pend_ext;
    end
    ll = in_word.mag[LIMB_W-1:0] * in_word.x2[LIMB_W-1:0];
  end

  // cross limb
  always_comb begin
    lh         = a_mag[LIMB_W-1:0] * a_x2[X2_W-1:LIMB_W];
    b_acc_next = ACC_W'(a_acc) + (ACC_W'(lh) << LIMB_W);
  end

  // high limb and Q56 to Q30 rescale
  always_comb begin
    hx     = b_mh * b_x2;
    c_full = b_acc + (ACC_W'(hx) << LIMB_W);
  end

  // reciprocal product, low limbs
  assign yl_ml = c_y[LIMB_W-1:0] * recip[LIMB_W-1:0];

  // reciprocal product, upper limbs and quotient estimate
  always_comb begin
    mid_prod = d_y[LIMB_W-1:0] * recip[RECIP_W-1:LIMB_W]
             + d_y[Y_W-1:LIMB_W] * recip[LIMB_W-1:0];
    hh       = d_y[Y_W-1:LIMB_W] * recip[RECIP_W-1:LIMB_W];
    e_full   = PROD_W'(d_acc) + (PROD_W'(mid_prod) << LIMB_W)
             + (PROD_W'(hh) << (2 * LIMB_W));
  end

  // estimate back-multiplied by the divisor
  assign mprod = e_q0 * divisor;

  // estimate is low by at most one
  always_comb begin
    rem = f_y - f_prod;
    q   = (rem >= Y_W'(divisor)) ? f_q0 + Q0_W'(1) : f_q0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NSTAGE-2:0], in_valid};
    end
  end

  assign out_valid = v[NSTAGE-1];

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      a_sum  <= sum_next;
      a_x2   <= in_word.x2;
      a_mag  <= in_word.mag;
      a_neg  <= in_word.neg;
      a_acc  <= ll;

      b_sum  <= a_sum;
      b_x2   <= a_x2;
      b_mh   <= a_mag[MAG_W-1:LIMB_W];
      b_neg  <= a_neg;
      b_acc  <= b_acc_next;

      c_sum  <= b_sum;
      c_x2   <= b_x2;
      c_neg  <= b_neg;
      c_y    <= c_full[X2_FRAC+Y_W-1:X2_FRAC];

      d_sum  <= c_sum;
      d_x2   <= c_x2;
      d_neg  <= c_neg;
      d_y    <= c_y;
      d_acc  <= yl_ml;

      e_sum  <= d_sum;
      e_x2   <= d_x2;
      e_neg  <= d_neg;
      e_y    <= d_y;
      e_q0   <= e_full[PROD_W-1:RECIP_SHIFT];

      f_sum  <= e_sum;
      f_x2   <= e_x2;
      f_neg  <= e_neg;
      f_y    <= e_y;
      f_q0   <= e_q0;
      f_prod <= mprod[Y_W-1:0];

      out_word.sum <= f_sum;
      out_word.x2  <= f_x2;
      out_word.mag <= q[MAG_W-1:0];
      out_word.neg <= ~f_neg;
      out_word.en  <= term_en;
    end
  end

endmodule

@@ src/cos_squared_half_series.sv @@
// Top level of the cos^2(x/2) truncated series pipeline: config register,
// |x| and x^2 stages, the chain of csh_term stages, final add and clipping.
// Depends on csh_pkg and csh_term.
//
//   channel   signals                               word
//   input     in_valid / in_stall                   angle (Q4.28)
//   output    out_valid / out_stall                 value (Q2.30), saturated
//   config    psel penable pwrite paddr pwdata      term_count at byte address 0
//
// The path registers |x|, then x^2, then passes the register stages of each
// csh_term stage in turn, then a final add stage and a clipping stage.
// A new word is taken in every cycle while in_stall is low.
// in_stall is high exactly while a result waits in the output register under
// out_stall; the whole pipeline then holds, nothing is lost or repeated.
// Reset clears the valid bits and sets term_count to 32; there is no clearing pass.
module cos_squared_half_series
  import csh_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] value,
  output logic                      saturated,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  logic                 adv;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [TC_W-1:0]      term_count;
  logic [CMP_W-1:0]     tc_ext;
  logic [CMP_W-1:0]     count_clip;

  logic                 v_abs;
  logic [ANGLE_W-1:0]   ax;
  logic [ANGLE_W-1:0]   angle_u;
  logic                 v_sq;
  logic [X2_W-1:0]      x2;
  logic [2*ANGLE_W-1:0] x2_full;

  logic [MAX_TERMS:0]   bus_valid;
  term_word_t           bus [MAX_TERMS+1];
  logic [MAX_TERMS-1:0] term_en;

  logic                    v_fin;
  logic signed [SUM_W-1:0] fin_sum;
  logic signed [SUM_W-1:0] fin_next;
  logic signed [SUM_W-1:0] last_ext;
  term_word_t              last;

  // whole pipeline moves unless a result is held at the output
  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign reg_idx   = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= TC_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_TERM_COUNT: term_count <= pwdata[TC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TERM_COUNT: prdata = PDATA_W'(term_count);
      default:        prdata = '0;
    endcase
  end

  // term count clipped to the number of built stages
  always_comb begin
    tc_ext     = CMP_W'(term_count);
    count_clip = (tc_ext > CMP_W'(MAX_TERMS)) ? CMP_W'(MAX_TERMS) : tc_ext;
  end

  // |x| then x^2
  assign angle_u = angle;
  assign x2_full = ax * ax;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_abs <= 1'b0;
      v_sq  <= 1'b0;
    end else if (adv) begin
      v_abs <= in_valid;
      v_sq  <= v_abs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= angle[ANGLE_W-1] ? (~angle_u + ANGLE_W'(1)) : angle_u;
      x2 <= x2_full[X2_W-1:0];
    end
  end

  // seed word: empty sum, 1.0 pending
  assign bus_valid[0] = v_sq;
  always_comb begin
    bus[0].sum = '0;
    bus[0].x2  = x2;
    bus[0].mag = SEED;
    bus[0].neg = 1'b0;
    bus[0].en  = 1'b1;
  end

  // term stage chain, each with its own divisor and reciprocal
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_term
    localparam int unsigned N       = i + 1;
    localparam logic [63:0] DIVISOR = (N == 1) ? 64'd4 : 64'(2 * N) * 64'(2 * N - 1);
    localparam logic [63:0] RECIP   = (64'd1 << RECIP_SHIFT) / DIVISOR;

    assign term_en[i] = (CMP_W'(N) <= count_clip);

    csh_term u_term (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .divisor   (DIVISOR[DIV_W-1:0]),
      .recip     (RECIP[RECIP_W-1:0]),
      .term_en   (term_en[i]),
      .in_valid  (bus_valid[i]),
      .in_word   (bus[i]),
      .out_valid (bus_valid[i+1]),
      .out_word  (bus[i+1])
    );
  end

  // last pending term
  assign last = bus[MAX_TERMS];
  always_comb begin
    last_ext = signed'(SUM_W'(last.mag));
    if (!last.en) begin
      fin_next = last.sum;
    end else if (last.neg) begin
      fin_next = last.sum - last_ext;
    end else begin
      fin_next = last.sum + last_ext;
    end
  end

  // final add and output register valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_fin     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_fin     <= bus_valid[MAX_TERMS];
      out_valid <= v_fin;
    end
  end

  // clip to Q2.30
  always_ff @(posedge clk) begin
    if (adv) begin
      fin_sum <= fin_next;
      if (fin_sum > VALUE_MAX) begin
        value     <= CLIP_HI;
        saturated <= 1'b1;
      end else if (fin_sum < VALUE_MIN) begin
        value     <= CLIP_LO;
        saturated <= 1'b1;
      end else begin
        value     <= fin_sum[VALUE_W-1:0];
        saturated <= 1'b0;
      end
    end
  end

endmodule

@@ src/csh_checker.sv @@
// Port-level checks for cos_squared_half_series, bound to the top level.
// Depends on cos_squared_half_series_macros.svh and csh_pkg.
`include "cos_squared_half_series_macros.svh"

module csh_checker
  import csh_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [VALUE_W-1:0] value,
  input logic                      saturated
);

  // a held result stays offered
  `CSH_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "held word dropped")

  // input side stalls exactly while the output is blocked
  `CSH_ASSERT_IMP(a_stall_link, clk, rst, 1'b1, in_stall == (out_valid && out_stall), "stall mismatch")

  // a clipped result sits at one of the range ends
  `CSH_ASSERT_IMP(a_clip_end, clk, rst, out_valid && saturated, value == CLIP_HI || value == CLIP_LO, "clip value off range end")

  // the pipeline freezes behind a blocked output
  `CSH_ASSERT_NXT(a_freeze, clk, rst, out_valid && out_stall, $stable(value) && $stable(saturated), "held word changed")

endmodule

bind cos_squared_half_series csh_checker u_csh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value),
  .saturated (saturated)
);
